// File: src/rcsp_pkg.sv
// Shared constants and types for the RESP command stream parser.
package rcsp_pkg;

    // Number field limits
    localparam int unsigned CHARS_W             = 6;
    localparam logic [5:0]  MAX_CHARS_RESET     = 6'd32;
    localparam int unsigned COUNT_WIDTH_DEFAULT = 32;
    localparam int unsigned ARG_W               = 32;
    localparam int unsigned CNT_W               = 31;

    // Framing characters
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Classification of one byte
    typedef enum logic [2:0] {
        EV_FRAME   = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_ARG     = 3'd2,
        EV_CMD     = 3'd3,
        EV_ERR     = 3'd4
    } event_t;

endpackage

// File: src/rcsp_if.sv
// Channel interfaces: byte input, classified result and configuration write.
interface rcsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rcsp_result_if;
    import rcsp_pkg::*;
    logic               valid;
    logic               ready;
    event_t             event_res;
    logic [7:0]         payload_byte;
    logic [ARG_W-1:0]   arg_index;
    logic signed [ARG_W-1:0] arg_length;
    logic [CNT_W-1:0]   arg_count;

    modport source (output valid, output event_res, output payload_byte, output arg_index,
                    output arg_length, output arg_count, input ready);
    modport sink   (input valid, input event_res, input payload_byte, input arg_index,
                    input arg_length, input arg_count, output ready);
endinterface

interface rcsp_cfg_if;
    import rcsp_pkg::*;
    logic               valid;
    logic               ready;
    logic [CHARS_W-1:0] max_number_chars;

    modport source (output valid, output max_number_chars, input ready);
    modport sink   (input valid, input max_number_chars, output ready);
endinterface

// File: src/resp_command_stream_parser.sv
// Top level of the RESP command stream parser: byte-wise framing and classification.
//
//   channel  | role   | request carries
//   ---------+--------+---------------------------------------------------------
//   stream   | sink   | data_byte: one raw byte of the command stream
//   result   | source | event_res, payload_byte, arg_index, arg_length, arg_count
//   cfg      | sink   | max_number_chars: character limit (sign included) for count and length fields
//
// One byte per cycle unless the result side stalls; each byte passes the input
// register, then parse logic into the result register, before its result request.
// The parse step is a single pass: compare, a times-ten accumulate and a phase update.
// rst_n clears the parse state, both stage valids and sets max_number_chars to 32.
// A stalled result holds the parse stage; the input register still fills, then
// stream.ready drops. cfg.ready is always high.
module resp_command_stream_parser #(
    parameter int unsigned COUNT_WIDTH = rcsp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    rcsp_byte_if.sink     stream,
    rcsp_result_if.source result,
    rcsp_cfg_if.sink      cfg
);
    import rcsp_pkg::*;

    // Magnitude of a number is capped at 2^(COUNT_WIDTH-1)-1, never above 2^31-1
    localparam int unsigned ACC_W = (COUNT_WIDTH - 1 < 31) ? COUNT_WIDTH - 1 : 31;

    typedef enum logic [3:0] {
        PH_WAIT, PH_ANUM, PH_ALF, PH_DOLLAR, PH_BNUM, PH_BLF, PH_BODY, PH_BCR, PH_BLF2
    } phase_t;

    // Configuration
    logic [CHARS_W-1:0] max_chars_reg;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parse state
    phase_t             phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [CHARS_W-1:0] dcount_reg, dcount_next;
    logic [ACC_W-1:0]   rem_reg, rem_next;
    logic [ACC_W-1:0]   idx_reg, idx_next;
    logic [ACC_W-1:0]   body_reg, body_next;
    logic [ARG_W-1:0]   len_reg, len_next;

    // Result stage
    logic               out_valid_reg;
    event_t             ev_reg, ev_next;
    logic [7:0]         pb_reg, pb_next;
    logic [ARG_W-1:0]   oidx_reg;
    logic [ARG_W-1:0]   olen_reg, olen_next;
    logic [CNT_W-1:0]   ocnt_reg;

    logic               advance;
    logic               proc;
    logic               err;
    logic               do_clear;
    logic               is_digit;
    logic [ACC_W+3:0]   acc_x10;
    logic [ACC_W-1:0]   cnt_sum;
    logic [7:0]         b;

    assign advance      = !out_valid_reg || result.ready;
    assign proc         = in_valid_reg && advance;
    assign stream.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    assign b        = in_byte_reg;
    assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign acc_x10  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                      + {{ACC_W{1'b0}}, b[3:0]};
    assign cnt_sum  = idx_reg + rem_reg;

    // Parse one byte: next state and the classification of this byte
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        dcount_next = dcount_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        body_next   = body_reg;
        len_next    = len_reg;
        ev_next     = EV_FRAME;
        pb_next     = 8'd0;
        olen_next   = len_reg;
        err         = 1'b0;
        do_clear    = 1'b0;

        unique case (phase_reg)
            PH_ANUM, PH_BNUM:
            begin
                if (b == CHAR_CR) begin
                    if (neg_reg && dcount_reg == CHARS_W'(1)) begin
                        err = 1'b1;
                    end else begin
                        phase_next = (phase_reg == PH_ANUM) ? PH_ALF : PH_BLF;
                    end
                end else if (dcount_reg >= max_chars_reg) begin
                    err = 1'b1;
                end else if (b == CHAR_MINUS && dcount_reg == '0) begin
                    neg_next    = 1'b1;
                    dcount_next = dcount_reg + 1'b1;
                end else if (is_digit) begin
                    if (acc_x10[ACC_W+3:ACC_W] != 4'd0) begin
                        err = 1'b1;
                    end else begin
                        acc_next    = acc_x10[ACC_W-1:0];
                        dcount_next = dcount_reg + 1'b1;
                    end
                end else begin
                    err = 1'b1;
                end
            end
            PH_ALF:
            begin
                if (b != CHAR_LF) begin
                    err = 1'b1;
                end else if (neg_reg || acc_reg == '0) begin
                    ev_next  = EV_CMD;
                    do_clear = 1'b1;
                end else begin
                    rem_next    = acc_reg;
                    idx_next    = '0;
                    acc_next    = '0;
                    neg_next    = 1'b0;
                    dcount_next = '0;
                    phase_next  = PH_DOLLAR;
                end
            end
            PH_DOLLAR:
            begin
                if (b != CHAR_DOLLAR) begin
                    err = 1'b1;
                end else begin
                    len_next    = '0;
                    olen_next   = '0;
                    acc_next    = '0;
                    neg_next    = 1'b0;
                    dcount_next = '0;
                    phase_next  = PH_BNUM;
                end
            end
            PH_BLF:
            begin
                if (b != CHAR_LF) begin
                    err = 1'b1;
                end else begin
                    acc_next    = '0;
                    neg_next    = 1'b0;
                    dcount_next = '0;
                    if (neg_reg && acc_reg != '0) begin
                        // Null argument: no body, finish it now
                        len_next  = '1;
                        olen_next = '1;
                        if (rem_reg <= ACC_W'(1)) begin
                            ev_next  = EV_CMD;
                            do_clear = 1'b1;
                        end else begin
                            ev_next    = EV_ARG;
                            rem_next   = rem_reg - 1'b1;
                            idx_next   = idx_reg + 1'b1;
                            phase_next = PH_DOLLAR;
                        end
                    end else begin
                        len_next   = ARG_W'(acc_reg);
                        olen_next  = ARG_W'(acc_reg);
                        body_next  = acc_reg;
                        phase_next = (acc_reg == '0) ? PH_BCR : PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                ev_next   = EV_PAYLOAD;
                pb_next   = b;
                body_next = body_reg - 1'b1;
                if (body_reg == ACC_W'(1)) begin
                    phase_next = PH_BCR;
                end
            end
            PH_BCR:
            begin
                if (b != CHAR_CR) begin
                    err = 1'b1;
                end else begin
                    phase_next = PH_BLF2;
                end
            end
            PH_BLF2:
            begin
                if (b != CHAR_LF) begin
                    err = 1'b1;
                end else if (rem_reg <= ACC_W'(1)) begin
                    ev_next  = EV_CMD;
                    do_clear = 1'b1;
                end else begin
                    ev_next    = EV_ARG;
                    rem_next   = rem_reg - 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    phase_next = PH_DOLLAR;
                end
            end
            default:
            begin
                if (b != CHAR_STAR) begin
                    err = 1'b1;
                end else begin
                    do_clear = 1'b1;
                end
            end
        endcase

        // Drop back to waiting on a syntax error
        if (err) begin
            ev_next   = EV_ERR;
            pb_next   = 8'd0;
            olen_next = len_reg;
            do_clear  = 1'b1;
        end

        if (do_clear) begin
            phase_next  = PH_WAIT;
            acc_next    = '0;
            neg_next    = 1'b0;
            dcount_next = '0;
            rem_next    = '0;
            idx_next    = '0;
            body_next   = '0;
            len_next    = '0;
        end

        // A valid star opens a count field
        if (!err && phase_reg == PH_WAIT) begin
            phase_next = PH_ANUM;
        end
    end

    // Hold configuration, input stage, parse state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_chars_reg <= MAX_CHARS_RESET;
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_WAIT;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            dcount_reg    <= '0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            body_reg      <= '0;
            len_reg       <= '0;
            ev_reg        <= EV_FRAME;
            pb_reg        <= '0;
            oidx_reg      <= '0;
            olen_reg      <= '0;
            ocnt_reg      <= '0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                max_chars_reg <= cfg.max_number_chars;
            end
            if (stream.ready) begin
                in_valid_reg <= stream.valid;
                in_byte_reg  <= stream.data_byte;
            end
            if (proc) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                acc_reg       <= acc_next;
                neg_reg       <= neg_next;
                dcount_reg    <= dcount_next;
                rem_reg       <= rem_next;
                idx_reg       <= idx_next;
                body_reg      <= body_next;
                len_reg       <= len_next;
                ev_reg        <= ev_next;
                pb_reg        <= pb_next;
                oidx_reg      <= ARG_W'(idx_reg);
                olen_reg      <= olen_next;
                ocnt_reg      <= CNT_W'(cnt_sum);
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.event_res    = ev_reg;
    assign result.payload_byte = pb_reg;
    assign result.arg_index    = oidx_reg;
    assign result.arg_length   = olen_reg;
    assign result.arg_count    = ocnt_reg;

    // Command end and syntax error both return the parser to waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && (ev_next == EV_CMD || ev_next == EV_ERR)) |=> (phase_reg == PH_WAIT))
        else $error("parser not back to waiting after command end or error");

    // Body phase always has bytes left to take
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (body_reg != '0))
        else $error("body phase with no bytes remaining");

    // Outside a command no argument bookkeeping survives
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> (rem_reg == '0 && idx_reg == '0 && len_reg == '0))
        else $error("argument state left over while waiting for a command");

endmodule

// File: tb/sv/resp_command_stream_parser_test.sv
`timescale 1ns / 1ps
// Testbench of the RESP command stream parser: directed table, random commands, byte predictor.
module resp_command_stream_parser_test;
    import rcsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned PHASE_BYTES = 275;
    localparam int unsigned NUM_PHASES  = 7;
    localparam int unsigned REPORT_CAP  = 100;
    localparam int unsigned DRAIN_WAIT  = 4;
    localparam logic [31:0] MAG_LIMIT   = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_WAIT_STAR,
        ST_COUNT_NUM,
        ST_COUNT_LF,
        ST_DOLLAR,
        ST_LEN_NUM,
        ST_LEN_LF,
        ST_BODY,
        ST_BODY_CR,
        ST_BODY_LF
    } parse_state_t;

    typedef struct {
        event_t                  ev;
        logic [7:0]              payload;
        logic [ARG_W-1:0]        index;
        logic signed [ARG_W-1:0] length;
        logic [CNT_W-1:0]        count;
    } byte_class_t;

    typedef struct {
        logic [7:0] data;
        bit         typed;
        event_t     ev;
    } stim_row_t;

    logic clk;
    logic rst_n;

    rcsp_byte_if   stream_if ();
    rcsp_result_if result_if ();
    rcsp_cfg_if    cfg_if ();

    resp_command_stream_parser i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // Directed bytes; an event is typed in only where it is obvious
    stim_row_t directed_rows [29] = '{
        '{8'hFF,       1'b1, EV_ERR},
        '{CHAR_STAR,   1'b0, EV_FRAME},
        '{"1",         1'b0, EV_FRAME},
        '{CHAR_CR,     1'b0, EV_FRAME},
        '{CHAR_LF,     1'b0, EV_FRAME},
        '{CHAR_DOLLAR, 1'b0, EV_FRAME},
        '{"2",         1'b0, EV_FRAME},
        '{CHAR_CR,     1'b0, EV_FRAME},
        '{CHAR_LF,     1'b0, EV_FRAME},
        '{8'h00,       1'b1, EV_PAYLOAD},
        '{8'hFF,       1'b1, EV_PAYLOAD},
        '{CHAR_CR,     1'b0, EV_FRAME},
        '{CHAR_LF,     1'b1, EV_CMD},
        '{CHAR_STAR,   1'b0, EV_FRAME},
        '{CHAR_MINUS,  1'b0, EV_FRAME},
        '{CHAR_CR,     1'b1, EV_ERR},
        '{CHAR_STAR,   1'b0, EV_FRAME},
        '{CHAR_CR,     1'b0, EV_FRAME},
        '{CHAR_LF,     1'b1, EV_CMD},
        '{CHAR_STAR,   1'b0, EV_FRAME},
        '{"2",         1'b0, EV_FRAME},
        '{CHAR_CR,     1'b0, EV_FRAME},
        '{CHAR_LF,     1'b0, EV_FRAME},
        '{CHAR_DOLLAR, 1'b0, EV_FRAME},
        '{CHAR_MINUS,  1'b0, EV_FRAME},
        '{"1",         1'b0, EV_FRAME},
        '{CHAR_CR,     1'b0, EV_FRAME},
        '{CHAR_LF,     1'b1, EV_ARG},
        '{"x",         1'b1, EV_ERR}
    };

    // Predictor state
    logic [5:0]   char_limit;
    parse_state_t pstate;
    logic [31:0]  num_mag;
    bit           num_neg;
    int unsigned  num_chars;
    logic [31:0]  args_left;
    logic [31:0]  arg_idx;
    logic [31:0]  body_left;
    logic [31:0]  arg_len;

    byte_class_t  parse_results_due [$];
    logic [7:0]   pending_bytes [$];

    int unsigned  fail_count;
    int unsigned  bytes_sent;
    int unsigned  source_gap_max;
    int unsigned  sink_gap_max;
    int unsigned  hold_asked;
    int unsigned  hold_done;
    int unsigned  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_field();
        num_mag   = '0;
        num_neg   = 1'b0;
        num_chars = 0;
    endfunction

    function automatic void clear_command();
        clear_field();
        pstate    = ST_WAIT_STAR;
        args_left = '0;
        arg_idx   = '0;
        body_left = '0;
        arg_len   = '0;
    endfunction

    // Report the fields as they stand when called; a caller that changes the length does so first
    function automatic byte_class_t snapshot(event_t ev, logic [7:0] pb);
        byte_class_t r;
        logic [31:0] total;
        total     = arg_idx + args_left;
        r.ev      = ev;
        r.payload = pb;
        r.index   = arg_idx;
        r.length  = arg_len;
        r.count   = total[CNT_W-1:0];
        return r;
    endfunction

    // Take one character of a count or length field; 0 means syntax error
    function automatic bit accept_number_char(logic [7:0] b);
        longint unsigned v;
        if (num_chars >= char_limit)
            return 1'b0;
        if (b == CHAR_MINUS && num_chars == 0)
        begin
            num_neg = 1'b1;
            num_chars++;
            return 1'b1;
        end
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            v = 64'(num_mag) * 64'd10 + 64'(b - CHAR_ZERO);
            if (v > 64'(MAG_LIMIT))
                return 1'b0;
            num_mag = v[31:0];
            num_chars++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Close the current argument, and the command with its last one
    function automatic byte_class_t end_argument();
        byte_class_t r;
        bit          last;
        last = (args_left <= 1);
        r = snapshot(last ? EV_CMD : EV_ARG, 8'h00);
        if (last)
            clear_command();
        else
        begin
            args_left--;
            arg_idx++;
            pstate = ST_DOLLAR;
        end
        return r;
    endfunction

    // Classify one stream byte and advance the parse state
    function automatic byte_class_t classify_byte(logic [7:0] b);
        byte_class_t r;
        bit          ok;
        ok = 1'b1;
        r = snapshot(EV_FRAME, 8'h00);
        case (pstate)
            ST_COUNT_NUM, ST_LEN_NUM:
            begin
                if (b == CHAR_CR)
                begin
                    ok = !(num_neg && num_chars == 1);
                    if (ok)
                        pstate = (pstate == ST_COUNT_NUM) ? ST_COUNT_LF : ST_LEN_LF;
                end
                else
                    ok = accept_number_char(b);
            end
            ST_COUNT_LF:
            begin
                if (b != CHAR_LF)
                    ok = 1'b0;
                else if (num_neg || num_mag == 0)
                begin
                    r = snapshot(EV_CMD, 8'h00);
                    clear_command();
                end
                else
                begin
                    args_left = num_mag;
                    arg_idx   = '0;
                    clear_field();
                    pstate = ST_DOLLAR;
                end
            end
            ST_DOLLAR:
            begin
                if (b != CHAR_DOLLAR)
                    ok = 1'b0;
                else
                begin
                    arg_len = '0;
                    r = snapshot(EV_FRAME, 8'h00);
                    clear_field();
                    pstate = ST_LEN_NUM;
                end
            end
            ST_LEN_LF:
            begin
                if (b != CHAR_LF)
                    ok = 1'b0;
                else if (num_neg && num_mag != 0)
                begin
                    // null argument: no body follows
                    arg_len = '1;
                    clear_field();
                    r = end_argument();
                end
                else
                begin
                    arg_len   = num_mag;
                    body_left = num_mag;
                    clear_field();
                    r = snapshot(EV_FRAME, 8'h00);
                    pstate = (body_left == 0) ? ST_BODY_CR : ST_BODY;
                end
            end
            ST_BODY:
            begin
                r = snapshot(EV_PAYLOAD, b);
                body_left--;
                if (body_left == 0)
                    pstate = ST_BODY_CR;
            end
            ST_BODY_CR:
            begin
                if (b != CHAR_CR)
                    ok = 1'b0;
                else
                    pstate = ST_BODY_LF;
            end
            ST_BODY_LF:
            begin
                if (b != CHAR_LF)
                    ok = 1'b0;
                else
                    r = end_argument();
            end
            default:
            begin
                if (b != CHAR_STAR)
                    ok = 1'b0;
                else
                begin
                    clear_command();
                    r = snapshot(EV_FRAME, 8'h00);
                    pstate = ST_COUNT_NUM;
                end
            end
        endcase
        if (!ok)
        begin
            r = snapshot(EV_ERR, 8'h00);
            clear_command();
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (fail_count < REPORT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Compare the accepted result request with the oldest one due
    task automatic check_result();
        byte_class_t want;
        if (parse_results_due.size() == 0)
            report_mismatch($sformatf("unexpected result, event %0d", result_if.event_res));
        else
        begin
            want = parse_results_due.pop_front();
            if (result_if.event_res !== want.ev)
                report_mismatch($sformatf("event_res got %0d want %0d",
                                          result_if.event_res, want.ev));
            if (result_if.payload_byte !== want.payload)
                report_mismatch($sformatf("payload_byte got %h want %h",
                                          result_if.payload_byte, want.payload));
            if (result_if.arg_index !== want.index)
                report_mismatch($sformatf("arg_index got %0d want %0d",
                                          result_if.arg_index, want.index));
            if (result_if.arg_length !== want.length)
                report_mismatch($sformatf("arg_length got %0d want %0d",
                                          result_if.arg_length, want.length));
            if (result_if.arg_count !== want.count)
                report_mismatch($sformatf("arg_count got %0d want %0d",
                                          result_if.arg_count, want.count));
        end
    endtask

    // Offer one byte request after a random gap; predict it once accepted
    task automatic send_byte(logic [7:0] b, bit typed, event_t typed_ev);
        int unsigned gap;
        byte_class_t want;
        gap = $urandom_range(0, source_gap_max);
        if (gap > 0)
        begin
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= b;
        do @(posedge clk); while (!stream_if.ready);
        want = classify_byte(b);
        if (typed)
            want.ev = typed_ev;
        parse_results_due.push_back(want);
        bytes_sent++;
    endtask

    // Hold the input until every result is in, then cover the pipeline latency
    task automatic drain();
        stream_if.valid <= 1'b0;
        while (parse_results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_char_limit(logic [5:0] value);
        cfg_if.valid            <= 1'b1;
        cfg_if.max_number_chars <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        char_limit = value;
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
    endfunction

    function automatic void push_crlf();
        pending_bytes.push_back(CHAR_CR);
        pending_bytes.push_back(CHAR_LF);
    endfunction

    function automatic string zeros_text(int unsigned n);
        string s;
        s = "";
        repeat (n) s = {s, "0"};
        return s;
    endfunction

    function automatic logic [7:0] random_body_byte();
        case ($urandom_range(0, 9))
            0: return CHAR_CR;
            1: return CHAR_LF;
            2: return CHAR_STAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Emit a count field; return how many arguments to follow with
    function automatic int unsigned push_count_field();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        n = $urandom_range(1, 4);
        if (pick < 60)
            push_text($sformatf("%0d", n));
        else if (pick < 66)
        begin
            push_text("0");
            n = 0;
        end
        else if (pick < 72)
        begin
            push_text($sformatf("-%0d", n));
            n = 0;
        end
        else if (pick < 76)
        begin
            push_text("-0");
            n = 0;
        end
        else if (pick < 80)
            n = 0;
        else if (pick < 83)
        begin
            push_text("-");
            n = 0;
        end
        else if (pick < 87)
        begin
            push_text("2147483647");
            n = 1;
        end
        else if (pick < 91)
        begin
            push_text($sformatf("%0d", 64'd2147483648 + $urandom_range(0, 9999)));
            n = 0;
        end
        else
            push_text({zeros_text($urandom_range(1, 40)), $sformatf("%0d", n)});
        return n;
    endfunction

    // Emit a length field; return the body size, -1 where no body follows
    function automatic int push_length_field();
        int unsigned pick;
        int          n;
        pick = $urandom_range(0, 99);
        n = $urandom_range(0, 8);
        if (pick < 62)
            push_text($sformatf("%0d", n));
        else if (pick < 72)
        begin
            push_text($sformatf("-%0d", $urandom_range(1, 9)));
            n = -1;
        end
        else if (pick < 76)
        begin
            push_text("-0");
            n = 0;
        end
        else if (pick < 80)
            n = 0;
        else if (pick < 84)
            push_text({zeros_text($urandom_range(1, 40)), $sformatf("%0d", n)});
        else if (pick < 87)
        begin
            push_text("9999999999");
            n = -1;
        end
        else if (pick < 90)
        begin
            push_text("-");
            n = -1;
        end
        else
        begin
            n = $urandom_range(0, 2);
            push_text($sformatf("%0d", n));
        end
        return n;
    endfunction

    // Build one command, sometimes with noise ahead or damage inside
    function automatic void compose_command();
        int unsigned args;
        int          body_len;
        int unsigned pos;
        pending_bytes.delete();
        if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom_range(0, 255)));
        pending_bytes.push_back(CHAR_STAR);
        args = push_count_field();
        push_crlf();
        repeat (args)
        begin
            pending_bytes.push_back(CHAR_DOLLAR);
            body_len = push_length_field();
            push_crlf();
            if (body_len >= 0)
            begin
                repeat (body_len) pending_bytes.push_back(random_body_byte());
                push_crlf();
            end
        end
        pos = $urandom_range(0, pending_bytes.size() - 1);
        if ($urandom_range(0, 99) < 10)
            pending_bytes[pos] = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 99) < 5)
            while (pending_bytes.size() > pos + 1) void'(pending_bytes.pop_back());
    endfunction

    // Result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int unsigned wait_cycles;
        bit          holding;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            holding = (hold_asked != hold_done);
            wait_cycles = holding ? HOLD_CYCLES : $urandom_range(0, sink_gap_max);
            if (wait_cycles > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            if (holding)
                hold_done = hold_asked;
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
            check_result();
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [5:0]  char_limits [NUM_PHASES];
        int unsigned phase_start;
        fail_count     = 0;
        bytes_sent     = 0;
        hold_asked     = 0;
        hold_done      = 0;
        source_gap_max = 13;
        sink_gap_max   = 13;
        char_limit     = MAX_CHARS_RESET;
        clear_command();
        char_limits = '{6'd9, 6'd1, 6'd0, 6'd63, 6'd32, 6'($urandom_range(0, 63)), 6'd10};

        rst_n                   <= 1'b0;
        stream_if.valid         <= 1'b0;
        stream_if.data_byte     <= 8'h00;
        cfg_if.valid            <= 1'b0;
        cfg_if.max_number_chars <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table at the reset digit limit
        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].ev);

        // Random commands, one digit limit and idle pattern per phase
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            write_char_limit(char_limits[ph]);
            source_gap_max = (ph % 3 == 0) ? 0 : 13;
            sink_gap_max   = (ph % 2 == 1) ? 0 : 13;
            phase_start    = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                compose_command();
                foreach (pending_bytes[i])
                    send_byte(pending_bytes[i], 1'b0, EV_FRAME);
                // ask the sink for one long stall while requests keep coming
                if (ph == 0 && hold_asked == 0 && bytes_sent - phase_start >= 100)
                    hold_asked = 1;
            end
        end

        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
